[src/nls_pkg.sv]
// Package: shared types and constants for the numeric literal scanner.
`default_nettype none
package nls_pkg;

    localparam int MAX_TEXT = 64;
    localparam int CNT_W    = $clog2(MAX_TEXT + 1);
    localparam int TEXT_W   = 7;
    localparam int IMAX_W   = 31;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [IMAX_W-1:0] INT_MAX_RESET = IMAX_W'(32767);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LL    = 8'h6c;
    localparam logic [7:0] CH_UL    = 8'h4c;
    localparam logic [7:0] LA_BIAS  = 8'h57;
    localparam logic [7:0] UA_BIAS  = 8'h37;

    typedef enum logic [1:0] {
        KIND_INT   = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_FLOAT = 2'd2,
        KIND_DOT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RAD_DEC = 2'd0,
        RAD_OCT = 2'd1,
        RAD_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } t_in_beat;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] value;
        logic [TEXT_W-1:0]  text_length;
        logic               syntax_error;
        logic               consumed;
    } t_out_beat;

    typedef struct packed {
        logic       first;
        logic       is_zero;
        logic       is_dec;
        logic       is_hex_alpha;
        logic [3:0] digit;
        logic       is_dot;
        logic       is_sign;
        logic       is_e;
        logic       is_x;
        logic       is_l;
    } t_cls;

endpackage
`default_nettype wire

[src/nls_front.sv]
// Front end: accept input beats and classify each character.
`default_nettype none
module nls_front
    import nls_pkg::*;
(
    input  wire t_in_beat i_beat,
    input  wire           i_valid,
    input  wire           i_space,
    output logic          o_ready,
    output logic          o_push,
    output t_cls          o_cls
);

    logic [7:0] c;
    logic       lower_hex;
    logic       upper_hex;
    logic [7:0] lower_off;
    logic [7:0] upper_off;
    logic [7:0] dec_off;

    assign c         = i_beat.ch;
    assign lower_hex = (c >= CH_LA) && (c <= CH_LF);
    assign upper_hex = (c >= CH_UA) && (c <= CH_UF);
    assign lower_off = c - LA_BIAS;
    assign upper_off = c - UA_BIAS;
    assign dec_off   = c - CH_0;

    assign o_ready = i_space;
    assign o_push  = i_valid && i_space;

    always_comb begin
        o_cls              = '0;
        o_cls.first        = i_beat.first;
        o_cls.is_zero      = (c == CH_0);
        o_cls.is_dec       = (c >= CH_0) && (c <= CH_9);
        o_cls.is_hex_alpha = lower_hex || upper_hex;
        o_cls.is_dot       = (c == CH_DOT);
        o_cls.is_sign      = (c == CH_PLUS) || (c == CH_MINUS);
        o_cls.is_e         = (c == CH_LE) || (c == CH_UE);
        o_cls.is_x         = (c == CH_LX) || (c == CH_UX);
        o_cls.is_l         = (c == CH_LL) || (c == CH_UL);
        if (lower_hex) begin
            o_cls.digit = lower_off[3:0];
        end else if (upper_hex) begin
            o_cls.digit = upper_off[3:0];
        end else begin
            o_cls.digit = dec_off[3:0];
        end
    end

endmodule
`default_nettype wire

[src/nls_queue.sv]
// Queue: short FIFO of classified characters between front and back.
`default_nettype none
module nls_queue
    import nls_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  wire t_cls  i_data,
    input  wire        i_pop,
    output logic       o_space,
    output logic       o_valid,
    output t_cls       o_data
);

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_space = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_head <= r_head + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/nls_back.sv]
// Back end: scan state, digit accumulation and result register.
`default_nettype none
module nls_back
    import nls_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [IMAX_W-1:0]  i_cfg_wdata,
    input  wire               i_q_valid,
    input  wire t_cls         i_cls,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output t_out_beat         o_out
);

    logic [IMAX_W-1:0] r_int_max;
    logic [31:0]       r_acc;
    t_radix            r_rad;
    logic              r_seen;
    logic [3:0]        r_lg;
    logic              r_flt;
    logic              r_exs;
    logic              r_aft;
    logic              r_err;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [31:0]       n_acc;
    t_radix            n_rad;
    logic              n_seen;
    logic [3:0]        n_lg;
    logic              n_flt;
    logic              n_exs;
    logic              n_aft;
    logic              n_err;
    logic [CNT_W-1:0]  n_cnt;

    logic              start;
    logic [31:0]       e_acc;
    t_radix            e_rad;
    logic              e_seen;
    logic [3:0]        e_lg;
    logic              e_flt;
    logic              e_exs;
    logic              e_aft;
    logic              e_err;
    logic [CNT_W-1:0]  e_cnt;
    logic [CNT_W-1:0]  cnt_inc;
    logic [31:0]       acc_dig;
    logic              hexl;
    logic              fin;
    t_kind             fin_kind;
    logic              fin_cons;
    logic              digit_bad;
    logic              promote;
    t_out_beat         res;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign start  = i_cls.first || (r_cnt == '0);
    assign e_acc  = start ? '0 : r_acc;
    assign e_seen = start ? 1'b0 : r_seen;
    assign e_lg   = start ? '0 : r_lg;
    assign e_flt  = start ? 1'b0 : r_flt;
    assign e_exs  = start ? 1'b0 : r_exs;
    assign e_aft  = start ? 1'b0 : r_aft;
    assign e_err  = start ? 1'b0 : r_err;
    assign e_cnt  = start ? '0 : r_cnt;

    always_comb begin
        if (start) begin
            e_rad = i_cls.is_zero ? RAD_OCT : RAD_DEC;
        end else begin
            e_rad = r_rad;
        end
    end

    assign cnt_inc = (e_cnt < CNT_W'(MAX_TEXT)) ? e_cnt + 1'b1 : e_cnt;
    assign hexl    = i_cls.is_hex_alpha && (e_rad == RAD_HEX);

    always_comb begin
        case (e_rad)
            RAD_OCT: begin
                acc_dig = {e_acc[28:0], 3'b000} + {28'd0, i_cls.digit};
            end
            RAD_HEX: begin
                acc_dig = {e_acc[27:0], 4'b0000} + {28'd0, i_cls.digit};
            end
            default: begin
                acc_dig = {e_acc[28:0], 3'b000} + {e_acc[30:0], 1'b0}
                        + {28'd0, i_cls.digit};
            end
        endcase
    end

    always_comb begin
        case (e_rad)
            RAD_OCT: digit_bad = e_lg[3];
            RAD_HEX: digit_bad = 1'b0;
            default: digit_bad = (e_lg >= 4'd10);
        endcase
    end

    assign promote = e_acc[31]
                   || ((e_acc > {1'b0, r_int_max}) && (e_rad == RAD_DEC))
                   || (e_acc[31:1] > r_int_max);

    always_comb begin
        n_acc    = e_acc;
        n_rad    = e_rad;
        n_seen   = e_seen;
        n_lg     = e_lg;
        n_flt    = e_flt;
        n_exs    = e_exs;
        n_aft    = e_aft;
        n_err    = e_err;
        n_cnt    = cnt_inc;
        fin      = 1'b0;
        fin_kind = e_flt ? KIND_FLOAT : KIND_INT;
        fin_cons = 1'b0;
        if (e_aft) begin
            n_aft = 1'b0;
            if (!(i_cls.is_sign || i_cls.is_dec)) begin
                fin = 1'b1;
            end
        end else if (i_cls.is_dec || hexl) begin
            n_acc  = acc_dig;
            n_seen = 1'b1;
            if (i_cls.digit > e_lg) begin
                n_lg = i_cls.digit;
            end
        end else if (i_cls.is_dot) begin
            if ((e_rad == RAD_HEX) || e_flt) begin
                n_err = 1'b1;
            end
            n_flt = 1'b1;
            n_rad = RAD_DEC;
        end else if (!e_seen) begin
            fin      = 1'b1;
            fin_kind = KIND_DOT;
        end else if (i_cls.is_e && !e_exs) begin
            n_exs = 1'b1;
            n_flt = 1'b1;
            if ((e_rad == RAD_HEX) || (e_lg >= 4'd10)) begin
                n_err = 1'b1;
            end
            n_rad = RAD_DEC;
            n_aft = 1'b1;
        end else if (i_cls.is_x) begin
            if ((e_rad != RAD_OCT) || (e_acc != '0) || e_flt) begin
                n_err = 1'b1;
            end
            n_rad = RAD_HEX;
        end else if (i_cls.is_l && !e_flt) begin
            fin      = 1'b1;
            fin_kind = KIND_LONG;
            fin_cons = 1'b1;
        end else begin
            fin = 1'b1;
        end
    end

    always_comb begin
        res              = '0;
        res.kind         = fin_kind;
        res.syntax_error = e_err || digit_bad;
        res.consumed     = fin_cons;
        case (fin_kind)
            KIND_FLOAT: begin
                res.text_length = TEXT_W'(cnt_inc);
            end
            KIND_DOT: begin
                res.value = '0;
            end
            KIND_INT: begin
                res.value = e_acc;
                if (promote) begin
                    res.kind = KIND_LONG;
                end
            end
            default: begin
                res.value = e_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && fin) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_max   <= INT_MAX_RESET;
            r_acc       <= '0;
            r_rad       <= RAD_DEC;
            r_seen      <= 1'b0;
            r_lg        <= '0;
            r_flt       <= 1'b0;
            r_exs       <= 1'b0;
            r_aft       <= 1'b0;
            r_err       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_int_max <= i_cfg_wdata;
            end
            if (o_pop) begin
                if (fin) begin
                    r_acc  <= '0;
                    r_rad  <= RAD_DEC;
                    r_seen <= 1'b0;
                    r_lg   <= '0;
                    r_flt  <= 1'b0;
                    r_exs  <= 1'b0;
                    r_aft  <= 1'b0;
                    r_err  <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_acc  <= n_acc;
                    r_rad  <= n_rad;
                    r_seen <= n_seen;
                    r_lg   <= n_lg;
                    r_flt  <= n_flt;
                    r_exs  <= n_exs;
                    r_aft  <= n_aft;
                    r_err  <= n_err;
                    r_cnt  <= n_cnt;
                end
            end
            if (o_pop && fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_new_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && fin) |=> (r_out_valid && (r_cnt == '0)))
        else $error("finished literal did not load result or clear scan");

    a_open_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !fin) |=> (r_cnt != '0))
        else $error("scan closed without a result");

    a_consumed_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.consumed) |-> (r_out.kind == KIND_LONG))
        else $error("consumed suffix without long kind");

    a_length_float_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind != KIND_FLOAT)) |-> (r_out.text_length == '0))
        else $error("text length reported for non-float token");
`endif

endmodule
`default_nettype wire

[src/numeric_literal_scanner.sv]
// A beat is registered in the queue, then its result in the output register.
// Throughput: one character per cycle in and out, unless the output stalls.
// A result waits in the output register; the four-entry queue absorbs output stalls.
// Reset: synchronous, active low; clears the queue, the scan state and the result
// valid flag, and sets int_max to 32767. No clearing pass follows reset.
// Top level: numeric literal scanner with front end, queue and back end.
`default_nettype none
module numeric_literal_scanner
    import nls_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire t_in_beat     i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output t_out_beat         o_out_data,
    input  wire               i_cfg_we,
    input  wire [IMAX_W-1:0]  i_cfg_wdata
);

    logic q_space;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cls front_cls;
    t_cls q_cls;

    nls_front u_front (
        .i_beat  (i_in_data),
        .i_valid (i_in_valid),
        .i_space (q_space),
        .o_ready (o_in_ready),
        .o_push  (q_push),
        .o_cls   (front_cls)
    );

    nls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cls),
        .i_pop   (q_pop),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_data  (q_cls)
    );

    nls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_cls       (q_cls),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for numeric_literal_scanner: random C literals checked against a token predictor.
module tb
    import nls_pkg::*;
();

    class token_scoreboard;
        logic [IMAX_W-1:0] int_max;
        logic [31:0]       acc;
        t_radix            radix;
        bit                seen_digit;
        logic [3:0]        big_digit;
        t_kind             tok_kind;
        bit                exp_seen;
        bit                after_exp;
        bit                err;
        int unsigned       nchars;
        t_out_beat         expected_tokens[$];
        int                errors;

        function new();
            int_max = INT_MAX_RESET;
            errors  = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            acc        = '0;
            radix      = RAD_DEC;
            seen_digit = 1'b0;
            big_digit  = '0;
            tok_kind   = KIND_INT;
            exp_seen   = 1'b0;
            after_exp  = 1'b0;
            err        = 1'b0;
            nchars     = 0;
        endfunction

        function int unsigned base();
            case (radix)
                RAD_OCT: return 8;
                RAD_HEX: return 16;
                default: return 10;
            endcase
        endfunction

        function void close_token(t_kind k, bit used);
            t_out_beat t;
            if (big_digit >= base())
                err = 1'b1;
            t.kind        = k;
            t.value       = '0;
            t.text_length = '0;
            if (k == KIND_FLOAT) begin
                t.text_length = nchars[TEXT_W-1:0];
            end else if (k != KIND_DOT) begin
                t.value = acc;
                if (k == KIND_INT && (acc[31] || (acc > {1'b0, int_max} && radix == RAD_DEC) ||
                                      (acc >> 1) > {1'b0, int_max}))
                    t.kind = KIND_LONG;
            end
            t.syntax_error = err;
            t.consumed     = used;
            expected_tokens.push_back(t);
            clear_scan();
        endfunction

        function void note_char(t_in_beat b);
            logic [7:0] c;
            bit         is_dec;
            bit         is_hex;
            logic [3:0] d;
            c = b.ch;
            if (b.first || nchars == 0) begin
                clear_scan();
                if (c == CH_0)
                    radix = RAD_OCT;
            end
            if (nchars < MAX_TEXT)
                nchars++;
            is_dec = c >= CH_0 && c <= CH_9;
            if (after_exp) begin
                after_exp = 1'b0;
                if (!(c == CH_PLUS || c == CH_MINUS || is_dec))
                    close_token(tok_kind, 1'b0);
                return;
            end
            is_hex = radix == RAD_HEX && ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF));
            if (is_dec || is_hex) begin
                if (is_dec)
                    d = 4'(c - CH_0);
                else if (c >= CH_LA)
                    d = 4'(c - LA_BIAS);
                else
                    d = 4'(c - UA_BIAS);
                acc = acc * base() + d;
                seen_digit = 1'b1;
                if (d > big_digit)
                    big_digit = d;
                return;
            end
            if (c == CH_DOT) begin
                if (radix == RAD_HEX || tok_kind == KIND_FLOAT)
                    err = 1'b1;
                tok_kind = KIND_FLOAT;
                radix    = RAD_DEC;
                return;
            end
            if (!seen_digit) begin
                close_token(KIND_DOT, 1'b0);
                return;
            end
            if ((c == CH_LE || c == CH_UE) && !exp_seen) begin
                exp_seen = 1'b1;
                tok_kind = KIND_FLOAT;
                if (radix == RAD_HEX || big_digit >= 10)
                    err = 1'b1;
                radix     = RAD_DEC;
                after_exp = 1'b1;
                return;
            end
            if (c == CH_LX || c == CH_UX) begin
                if (radix != RAD_OCT || acc != 0 || tok_kind != KIND_INT)
                    err = 1'b1;
                radix = RAD_HEX;
                return;
            end
            if ((c == CH_LL || c == CH_UL) && tok_kind == KIND_INT) begin
                close_token(KIND_LONG, 1'b1);
                return;
            end
            close_token(tok_kind, 1'b0);
        endfunction

        function void check_token(t_out_beat got);
            t_out_beat want;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token: expected none, got kind %0d value %0d len %0d",
                         $time, got.kind, got.value, got.text_length);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.text_length !== want.text_length || got.syntax_error !== want.syntax_error ||
                got.consumed !== want.consumed) begin
                errors++;
                $display("%0t: token mismatch: expected kind %0d value %0d len %0d err %0b used %0b",
                         $time, want.kind, want.value, want.text_length, want.syntax_error,
                         want.consumed);
                $display("%0t:                 actual kind %0d value %0d len %0d err %0b used %0b",
                         $time, got.kind, got.value, got.text_length, got.syntax_error,
                         got.consumed);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_beat          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_beat         o_out_data;
    logic              i_cfg_we;
    logic [IMAX_W-1:0] i_cfg_wdata;

    token_scoreboard sb;
    t_in_beat        lit_q[$];
    bit              pend_first;
    int              tx_idle_pct;
    int              rx_stall_pct;
    int              hold_left;
    int              sent;

    numeric_literal_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("numeric_literal_scanner test failed");
        $finish;
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_token(o_out_data);
    end

    function automatic void push_ch(logic [7:0] c);
        t_in_beat b;
        b.ch    = c;
        b.first = pend_first;
        lit_q.push_back(b);
        pend_first = 1'b0;
    endfunction

    function automatic void push_text(string s, bit f);
        pend_first = f;
        for (int i = 0; i < s.len(); i++)
            push_ch(s[i]);
    endfunction

    function automatic logic [7:0] dec_digit();
        return 8'(CH_0 + $urandom_range(9));
    endfunction

    function automatic logic [7:0] hex_digit();
        int d;
        d = $urandom_range(15);
        if (d < 10)
            return 8'(CH_0 + d);
        return 8'(($urandom_range(1) ? CH_LA : CH_UA) + d - 10);
    endfunction

    function automatic void gen_literal();
        string seps = " ;,)\n";
        string junk = "0123456789abcdefABCDEFxXeElL.+-";
        int    form;
        bit    is_int;
        is_int     = 1'b1;
        pend_first = ($urandom_range(9) != 0);
        form       = $urandom_range(99);
        if (form < 8) begin
            repeat ($urandom_range(1, 4)) begin
                pend_first = $urandom_range(1);
                push_ch(8'($urandom_range(255)));
            end
            return;
        end else if (form < 22) begin
            push_ch(8'(CH_0 + $urandom_range(1, 9)));
            repeat ($urandom_range(11)) push_ch(dec_digit());
        end else if (form < 36) begin
            push_ch(CH_0);
            repeat ($urandom_range(11))
                push_ch($urandom_range(99) < 85 ? 8'(CH_0 + $urandom_range(7)) : dec_digit());
        end else if (form < 54) begin
            push_ch(CH_0);
            push_ch($urandom_range(1) ? CH_LX : CH_UX);
            repeat ($urandom_range(1, 9)) push_ch(hex_digit());
        end else if (form < 72) begin
            is_int = 1'b0;
            repeat ($urandom_range(4)) push_ch(dec_digit());
            push_ch(CH_DOT);
            repeat ($urandom_range(4)) push_ch(dec_digit());
            if ($urandom_range(1)) begin
                push_ch($urandom_range(1) ? CH_LE : CH_UE);
                if ($urandom_range(1))
                    push_ch($urandom_range(1) ? CH_PLUS : CH_MINUS);
                repeat ($urandom_range(1, 3)) push_ch(dec_digit());
            end
        end else if (form < 76) begin
            is_int = 1'b0;
            push_ch(CH_DOT);
        end else if (form < 78) begin
            repeat ($urandom_range(60, 80)) push_ch(dec_digit());
        end else if (form < 88) begin
            repeat ($urandom_range(1, 8)) push_ch(junk[$urandom_range(junk.len() - 1)]);
        end else begin
            is_int = 1'b0;
            push_ch(dec_digit());
            push_ch($urandom_range(1) ? CH_LE : CH_UE);
        end
        if (is_int && $urandom_range(3) == 0)
            push_ch($urandom_range(1) ? CH_LL : CH_UL);
        else if ($urandom_range(9) != 0)
            push_ch($urandom_range(5) == 0 ? 8'($urandom_range(255))
                                          : seps[$urandom_range(seps.len() - 1)]);
    endfunction

    task automatic send_beat(t_in_beat b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_char(b);
        sent++;
    endtask

    task automatic send_all();
        while (lit_q.size() != 0)
            send_beat(lit_q.pop_front());
    endtask

    task automatic write_int_max(logic [IMAX_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.int_max = v;
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int n_items);
        int target;
        target       = sent + n_items;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        while (sent < target) begin
            gen_literal();
            send_all();
        end
        push_text(" ", 1'b0);
        send_all();
        i_in_valid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        sb           = new();
        sent         = 0;
        hold_left    = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_text("0x1F ", 1'b1);
        push_text("089L", 1'b1);
        push_text("1.5e+3;", 1'b1);
        push_text("7", 1'b1);
        push_text("99999 ", 1'b1);
        push_text(".", 1'b1);
        push_ch(8'hFF);
        pend_first = 1'b0;
        push_ch(8'h00);
        send_all();
        run_phase(0, 0, 170);

        write_int_max('0);
        run_phase(58, 0, 190);

        write_int_max({IMAX_W{1'b1}});
        repeat (70) push_ch(dec_digit());
        push_text(". ", 1'b0);
        send_all();
        run_phase(0, 58, 190);

        write_int_max(IMAX_W'($urandom()));
        run_phase(16, 16, 190);

        write_int_max(IMAX_W'(65535));
        hold_left = 400;
        run_phase(0, 0, 190);

        if (sb.errors == 0 && sb.expected_tokens.size() == 0)
            $display("numeric_literal_scanner test passed");
        else
            $display("numeric_literal_scanner test failed");
        $finish;
    end
endmodule
